FILE: sv/prq_pkg.sv
// shared types and codes for the priority ready queue scheduler
package prq_pkg;

   localparam int TASK_ID_W = 4;
   localparam int PRIO_W    = 3;

   typedef enum logic [1:0] {
      MODE_ENQUEUE  = 2'd0,
      MODE_DEQUEUE  = 2'd1,
      MODE_PREEMPT  = 2'd2,
      MODE_SCHEDULE = 2'd3
   } prq_mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE           = 2'd0,
      STATUS_NOT_FOUND      = 2'd1,
      STATUS_ALREADY_QUEUED = 2'd2
   } prq_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LVL_WAIT,
      S_WALK,
      S_WALK_WAIT,
      S_APPEND,
      S_APPEND_LINK,
      S_SCAN,
      S_RESP
   } prq_state_type;

   typedef struct packed {
      prq_mode_type         mode;
      logic [TASK_ID_W-1:0] task_id;
      logic [PRIO_W-1:0]    priority_req;
      logic [TASK_ID_W-1:0] current_task_id;
      logic                 current_valid;
   } prq_req_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0] next_task_id;
      logic                 reschedule_pending;
      prq_status_type       status;
   } prq_rsp_type;

endpackage

FILE: sv/prq_ram.sv
// generic single write, single read ram with registered read data
module prq_ram
   import prq_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/priority_ready_queue_scheduler_core.sv
// Multilevel priority round-robin ready queue: one FIFO ready list per level, linked over a task table.
//
// Operation: a transaction is taken when start is high and busy is low; busy then stays high until
// the single result has been strobed on rsp_valid for one cycle, and the receiver cannot stall it.
// Every walk step reads the linked-list table through its one registered read port: it issues the read
// (S_WALK), then takes the data (S_WALK_WAIT). Enqueue passes S_APPEND, plus S_APPEND_LINK if its level
// is not empty; dequeue reads the level, walks from the head to the task and splices it out; preempt
// walks for the current task if queued, then appends it; schedule with no pending flag goes straight
// to S_RESP, else scans the levels upward from level 0. busy drops the cycle after the strobe. The idle
// task id register may be written at any time the block is idle; csr_ready is always high.
module priority_ready_queue_scheduler_core
   import prq_pkg::*;
#(
   parameter int MAX_TASKS  = 16,
   parameter int NUM_LEVELS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  prq_req_type          req_data,
   output logic                 rsp_valid,
   output prq_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TASK_ID_W-1:0] csr_data
);

   localparam int TASK_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int LINK_W = TASK_W + 1;

   prq_state_type state_ff, state_in;
   prq_mode_type  mode_ff, mode_in;
   prq_status_type status_ff, status_in;

   logic [TASK_W-1:0]    t_ff, t_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic                 hit_ff, hit_in;
   logic                 flag_ff, flag_in;
   logic [TASK_ID_W-1:0] chosen_ff, chosen_in;
   logic [TASK_ID_W-1:0] idle_ff;
   logic [TASK_W-1:0]    cur_ff, cur_in;
   logic [TASK_W-1:0]    prev_ff, prev_in;
   logic                 prev_ok_ff, prev_ok_in;
   logic [LVL_W-1:0]     scan_ff, scan_in;
   logic [MAX_TASKS-1:0] queued_ff, queued_in;

   logic [TASK_W-1:0]     head_ff [NUM_LEVELS];
   logic [TASK_W-1:0]     head_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] head_ok_ff, head_ok_in;
   logic [TASK_W-1:0]     tail_ff [NUM_LEVELS];
   logic [TASK_W-1:0]     tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] tail_ok_ff, tail_ok_in;

   // ram controls
   logic              lvl_wr_en;
   logic [TASK_W-1:0] lvl_wr_addr;
   logic [LVL_W-1:0]  lvl_wr_data;
   logic [TASK_W-1:0] lvl_rd_addr;
   logic [LVL_W-1:0]  lvl_rd_data;
   logic              link_wr_en;
   logic [TASK_W-1:0] link_wr_addr;
   logic [LINK_W-1:0] link_wr_data;
   logic [TASK_W-1:0] link_rd_addr;
   logic [LINK_W-1:0] link_rd_data;
   logic              link_ok_rd;
   logic [TASK_W-1:0] link_next_rd;

   // request decode
   logic                    accept;
   logic [TASK_W+TASK_ID_W-1:0] tid_wide, cur_wide;
   logic [TASK_W-1:0]       tid_idx, cur_idx;
   logic                    tid_ok, cur_ok;
   logic [LVL_W+PRIO_W-1:0] prio_wide;
   logic [LVL_W-1:0]        prio_sat;
   logic [TASK_W+TASK_ID_W-1:0] head_wide;
   logic                    match;
   logic                    scan_last;

   assign accept    = start && !busy;
   assign tid_wide  = {{TASK_W{1'b0}}, req_data.task_id};
   assign cur_wide  = {{TASK_W{1'b0}}, req_data.current_task_id};
   assign tid_idx   = tid_wide[TASK_W-1:0];
   assign cur_idx   = cur_wide[TASK_W-1:0];
   assign tid_ok    = int'(req_data.task_id) < MAX_TASKS;
   assign cur_ok    = int'(req_data.current_task_id) < MAX_TASKS;
   assign prio_wide = {{LVL_W{1'b0}}, req_data.priority_req};
   assign prio_sat  = (int'(req_data.priority_req) >= NUM_LEVELS) ?
                      LVL_W'(NUM_LEVELS - 1) : prio_wide[LVL_W-1:0];
   assign head_wide = {{TASK_ID_W{1'b0}}, head_ff[scan_ff]};
   assign link_ok_rd   = link_rd_data[LINK_W-1];
   assign link_next_rd = link_rd_data[TASK_W-1:0];
   assign match     = (cur_ff == t_ff);
   assign scan_last = (int'(scan_ff) == NUM_LEVELS - 1);

   prq_ram #(.WIDTH(LVL_W), .DEPTH(MAX_TASKS)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_wr_en),
      .wr_addr (lvl_wr_addr),
      .wr_data (lvl_wr_data),
      .rd_addr (lvl_rd_addr),
      .rd_data (lvl_rd_data)
   );

   prq_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TASKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_ENQUEUE: begin
                     if (!tid_ok || queued_ff[tid_idx]) state_in = S_RESP;
                     else state_in = S_APPEND;
                  end
                  MODE_DEQUEUE: begin
                     if (!tid_ok || !queued_ff[tid_idx]) state_in = S_RESP;
                     else state_in = S_LVL_WAIT;
                  end
                  MODE_PREEMPT: begin
                     if (!req_data.current_valid || !cur_ok) state_in = S_RESP;
                     else state_in = S_LVL_WAIT;
                  end
                  MODE_SCHEDULE: begin
                     if (flag_ff) state_in = S_SCAN;
                     else state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_LVL_WAIT: begin
            if (queued_ff[t_ff]) state_in = S_WALK;
            else state_in = S_APPEND;
         end
         S_WALK: state_in = S_WALK_WAIT;
         S_WALK_WAIT: begin
            if (match || !link_ok_rd) begin
               if (mode_ff == MODE_DEQUEUE) state_in = S_RESP;
               else state_in = S_APPEND;
            end else begin
               state_in = S_WALK;
            end
         end
         S_APPEND: begin
            if (head_ok_ff[lvl_ff]) state_in = S_APPEND_LINK;
            else state_in = S_RESP;
         end
         S_APPEND_LINK: state_in = S_RESP;
         S_SCAN: begin
            if (head_ok_ff[scan_ff] || scan_last) state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      mode_in    = mode_ff;
      status_in  = status_ff;
      t_in       = t_ff;
      lvl_in     = lvl_ff;
      hit_in     = hit_ff;
      flag_in    = flag_ff;
      chosen_in  = chosen_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      prev_ok_in = prev_ok_ff;
      scan_in    = scan_ff;
      queued_in  = queued_ff;
      head_in    = head_ff;
      head_ok_in = head_ok_ff;
      tail_in    = tail_ff;
      tail_ok_in = tail_ok_ff;

      lvl_wr_en    = 1'b0;
      lvl_wr_addr  = tid_idx;
      lvl_wr_data  = prio_sat;
      lvl_rd_addr  = (req_data.mode == MODE_PREEMPT) ? cur_idx : tid_idx;
      link_wr_en   = 1'b0;
      link_wr_addr = t_ff;
      link_wr_data = '0;
      link_rd_addr = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = req_data.mode;
               status_in = STATUS_DONE;
               t_in      = (req_data.mode == MODE_PREEMPT) ? cur_idx : tid_idx;
               hit_in    = (req_data.current_valid &&
                            req_data.task_id == req_data.current_task_id) ||
                           (req_data.task_id == chosen_ff);
               scan_in   = '0;
               case (req_data.mode)
                  MODE_ENQUEUE: begin
                     if (!tid_ok) begin
                        status_in = STATUS_NOT_FOUND;
                     end else if (queued_ff[tid_idx]) begin
                        status_in = STATUS_ALREADY_QUEUED;
                     end else begin
                        lvl_in    = prio_sat;
                        lvl_wr_en = 1'b1;
                     end
                  end
                  MODE_DEQUEUE: begin
                     if (!tid_ok || !queued_ff[tid_idx]) status_in = STATUS_NOT_FOUND;
                  end
                  MODE_PREEMPT: begin
                     if (!req_data.current_valid || !cur_ok) status_in = STATUS_NOT_FOUND;
                  end
                  MODE_SCHEDULE: begin
                     if (flag_ff) begin
                        flag_in   = 1'b0;
                        chosen_in = idle_ff;
                     end
                  end
                  default: status_in = STATUS_DONE;
               endcase
            end
         end
         S_LVL_WAIT: begin
            lvl_in     = lvl_rd_data;
            cur_in     = head_ff[lvl_rd_data];
            prev_ok_in = 1'b0;
         end
         S_WALK: begin
            link_rd_addr = cur_ff;
         end
         S_WALK_WAIT: begin
            if (match) begin
               // splice the successor into the predecessor or the level head
               if (!prev_ok_ff) begin
                  head_in[lvl_ff]    = link_next_rd;
                  head_ok_in[lvl_ff] = link_ok_rd;
               end else begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = prev_ff;
                  link_wr_data = link_rd_data;
               end
               if (tail_ok_ff[lvl_ff] && tail_ff[lvl_ff] == t_ff) begin
                  tail_in[lvl_ff]    = prev_ff;
                  tail_ok_in[lvl_ff] = prev_ok_ff;
               end
               queued_in[t_ff] = 1'b0;
               if (mode_ff == MODE_DEQUEUE && hit_ff) flag_in = 1'b1;
            end else if (!link_ok_rd) begin
               if (mode_ff == MODE_DEQUEUE) status_in = STATUS_NOT_FOUND;
            end else begin
               prev_in    = cur_ff;
               prev_ok_in = 1'b1;
               cur_in     = link_next_rd;
            end
         end
         S_APPEND: begin
            link_wr_en      = 1'b1;
            link_wr_addr    = t_ff;
            link_wr_data    = '0;
            queued_in[t_ff] = 1'b1;
            flag_in         = 1'b1;
            if (!head_ok_ff[lvl_ff]) begin
               head_in[lvl_ff]    = t_ff;
               head_ok_in[lvl_ff] = 1'b1;
               tail_in[lvl_ff]    = t_ff;
               tail_ok_in[lvl_ff] = 1'b1;
            end
         end
         S_APPEND_LINK: begin
            link_wr_en         = 1'b1;
            link_wr_addr       = tail_ff[lvl_ff];
            link_wr_data       = {1'b1, t_ff};
            tail_in[lvl_ff]    = t_ff;
            tail_ok_in[lvl_ff] = 1'b1;
         end
         S_SCAN: begin
            if (head_ok_ff[scan_ff]) begin
               chosen_in = head_wide[TASK_ID_W-1:0];
            end else if (!scan_last) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         flag_ff    <= 1'b1;
         chosen_ff  <= '0;
         idle_ff    <= '0;
         queued_ff  <= '0;
         head_ok_ff <= '0;
         tail_ok_ff <= '0;
      end else begin
         state_ff   <= state_in;
         flag_ff    <= flag_in;
         chosen_ff  <= chosen_in;
         queued_ff  <= queued_in;
         head_ok_ff <= head_ok_in;
         tail_ok_ff <= tail_ok_in;
         if (csr_valid && csr_ready) begin
            idle_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      status_ff  <= status_in;
      t_ff       <= t_in;
      lvl_ff     <= lvl_in;
      hit_ff     <= hit_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      prev_ok_ff <= prev_ok_in;
      scan_ff    <= scan_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data.next_task_id       = chosen_ff;
   assign rsp_data.reschedule_pending = flag_ff;
   assign rsp_data.status             = status_ff;

   // one strobe per transaction, then back to idle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");

   // a schedule that ran always leaves the flag cleared
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff == MODE_SCHEDULE) |-> !flag_ff)
      else $error("schedule left reschedule pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff == MODE_ENQUEUE && status_ff == STATUS_DONE)
      |-> (queued_ff[t_ff] && flag_ff))
      else $error("enqueue done without queued task and flag");

   // a level has a head exactly when it has a tail
   assert property (@(posedge clock) disable iff (reset) head_ok_ff == tail_ok_ff)
      else $error("level head and tail validity disagree");

endmodule
